// ===== rtl/tltc_pkg.sv =====
package tltc_pkg;

	localparam int CNT_W    = 7;
	localparam int REQ_W    = 2;
	localparam int CODE_W   = 2;
	localparam int LIGHT_W  = 2;
	localparam int DIGIT_W  = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] PHASE_RESET  = CNT_W'(20);
	localparam logic [CNT_W-1:0] YELLOW_RESET = CNT_W'(5);

	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_POINT = 1'b1;

	typedef enum logic [LIGHT_W-1:0] {
		LIGHT_GREEN  = 2'd0,
		LIGHT_YELLOW = 2'd1,
		LIGHT_RED    = 2'd2
	} light_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_FORCE = 2'd2
	} req_t;

	typedef enum logic [CODE_W-1:0] {
		FORCE_A_GREEN  = 2'd0,
		FORCE_B_GREEN  = 2'd1,
		FORCE_A_YELLOW = 2'd2,
		FORCE_B_YELLOW = 2'd3
	} force_t;

	// Green -> yellow -> red -> green; the unused code wraps to green.
	function automatic light_t next_light(light_t l);
		light_t n;
		unique case (l)
			LIGHT_GREEN:  n = LIGHT_YELLOW;
			LIGHT_YELLOW: n = LIGHT_RED;
			default:      n = LIGHT_GREEN;
		endcase
		return n;
	endfunction

	// Two decimal digits {tens, ones} of a 7-bit value; hundreds are dropped.
	// The quotient by ten is a multiply by 205/2048, exact below 1029.
	function automatic logic [2*DIGIT_W-1:0] to_digits(logic [CNT_W-1:0] v);
		logic [CNT_W+7:0]   prod;
		logic [DIGIT_W-1:0] q;
		logic [CNT_W-1:0]   q_x10;
		logic [CNT_W-1:0]   rem;
		logic [DIGIT_W-1:0] tens;
		prod  = (CNT_W+8)'(v) * (CNT_W+8)'(205);
		q     = prod[CNT_W+7:11];
		q_x10 = CNT_W'({q, 3'b000}) + CNT_W'({q, 1'b0});
		rem   = v - q_x10;
		tens  = (q >= DIGIT_W'(10)) ? (q - DIGIT_W'(10)) : q;
		return {tens, rem[DIGIT_W-1:0]};
	endfunction

endpackage

// ===== rtl/tltc_req_if.sv =====
interface tltc_req_if;
	logic                          valid;
	logic                          ready;
	logic [tltc_pkg::REQ_W-1:0]    req_type;
	logic [tltc_pkg::CODE_W-1:0]   force_code;

	modport source (output valid, req_type, force_code, input ready);
	modport sink   (input valid, req_type, force_code, output ready);
endinterface

// ===== rtl/tltc_rsp_if.sv =====
interface tltc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tltc_pkg::LIGHT_W-1:0]  light_a;
	logic [tltc_pkg::LIGHT_W-1:0]  light_b;
	logic [tltc_pkg::DIGIT_W-1:0]  a_tens;
	logic [tltc_pkg::DIGIT_W-1:0]  a_ones;
	logic [tltc_pkg::DIGIT_W-1:0]  b_tens;
	logic [tltc_pkg::DIGIT_W-1:0]  b_ones;
	logic                          changed;

	modport source (output valid, light_a, light_b, a_tens, a_ones, b_tens, b_ones, changed,
		input ready);
	modport sink   (input valid, light_a, light_b, a_tens, a_ones, b_tens, b_ones, changed,
		output ready);
endinterface

// ===== rtl/two_way_traffic_light_controller.sv =====
// Two-way traffic light controller. Each request item (tick, start or forced
// setting) yields exactly one result item with both lights, the two-digit
// countdown of each light and a changed flag. An item is registered on entry,
// then the countdown, light update and digit conversion are done combinationally
// into the result register, and a new item is taken every cycle as long as the
// result side keeps taking results. The user must write the phase length and
// yellow point registers through the cfg port only while no item is in flight;
// the block itself does not enforce this. Writes leave the running count alone.
module two_way_traffic_light_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tltc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tltc_pkg::CNT_W-1:0]          cfg_data,
	tltc_req_if.sink                            req,
	tltc_rsp_if.source                          rsp
);

	// Entry stage.
	logic                             valid_s1;
	logic [tltc_pkg::REQ_W-1:0]       req_type_s1;
	logic [tltc_pkg::CODE_W-1:0]      force_code_s1;

	// Configuration and controller state.
	logic [tltc_pkg::CNT_W-1:0]       phase_q;
	logic [tltc_pkg::CNT_W-1:0]       yellow_q;
	logic [tltc_pkg::CNT_W-1:0]       count_q;
	tltc_pkg::light_t                 state_a_q;
	tltc_pkg::light_t                 state_b_q;
	logic                             enabled_q;

	// Result register.
	logic                             rsp_valid_q;
	logic [tltc_pkg::LIGHT_W-1:0]     light_a_q;
	logic [tltc_pkg::LIGHT_W-1:0]     light_b_q;
	logic [2*tltc_pkg::DIGIT_W-1:0]   a_digits_q;
	logic [2*tltc_pkg::DIGIT_W-1:0]   b_digits_q;
	logic                             changed_q;

	logic                             adv_s2;
	logic                             in_fire;

	logic [tltc_pkg::CNT_W-1:0]       count_d;
	logic [tltc_pkg::CNT_W-1:0]       count_dec;
	tltc_pkg::light_t                 state_a_d;
	tltc_pkg::light_t                 state_b_d;
	logic                             enabled_d;
	logic                             changed_d;
	logic [tltc_pkg::CNT_W-1:0]       green_left;
	logic [tltc_pkg::CNT_W-1:0]       va;
	logic [tltc_pkg::CNT_W-1:0]       vb;

	assign adv_s2    = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s2;
	assign in_fire   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_type_s1   <= req.req_type;
			force_code_s1 <= req.force_code;
		end
	end

	always_comb begin
		count_dec = count_q - tltc_pkg::CNT_W'(1);
		count_d   = count_q;
		state_a_d = state_a_q;
		state_b_d = state_b_q;
		enabled_d = enabled_q;
		changed_d = 1'b0;
		unique case (req_type_s1)
			tltc_pkg::REQ_TICK: begin
				if (enabled_q) begin
					count_d = (count_dec == '0) ? phase_q : count_dec;
					if (count_d == yellow_q) begin
						// Only one green light turns yellow; A has priority.
						if (state_a_q == tltc_pkg::LIGHT_GREEN) begin
							state_a_d = tltc_pkg::LIGHT_YELLOW;
						end else if (state_b_q == tltc_pkg::LIGHT_GREEN) begin
							state_b_d = tltc_pkg::LIGHT_YELLOW;
						end
						changed_d = 1'b1;
					end else if (count_d == phase_q) begin
						state_a_d = tltc_pkg::next_light(state_a_q);
						state_b_d = tltc_pkg::next_light(state_b_q);
						changed_d = 1'b1;
					end
				end
			end
			tltc_pkg::REQ_START: begin
				enabled_d = 1'b1;
				changed_d = !enabled_q;
			end
			tltc_pkg::REQ_FORCE: begin
				changed_d = 1'b1;
				unique case (force_code_s1)
					tltc_pkg::FORCE_A_GREEN: begin
						state_a_d = tltc_pkg::LIGHT_GREEN;
						state_b_d = tltc_pkg::LIGHT_RED;
						count_d   = phase_q;
					end
					tltc_pkg::FORCE_B_GREEN: begin
						state_a_d = tltc_pkg::LIGHT_RED;
						state_b_d = tltc_pkg::LIGHT_GREEN;
						count_d   = phase_q;
					end
					tltc_pkg::FORCE_A_YELLOW: begin
						state_a_d = tltc_pkg::LIGHT_YELLOW;
						state_b_d = tltc_pkg::LIGHT_RED;
						count_d   = yellow_q;
					end
					default: begin
						state_a_d = tltc_pkg::LIGHT_RED;
						state_b_d = tltc_pkg::LIGHT_YELLOW;
						count_d   = yellow_q;
					end
				endcase
			end
			default: begin
			end
		endcase

		// A green light counts down to its yellow point, not to the phase end.
		green_left = (count_d > yellow_q) ? (count_d - yellow_q) : '0;
		va = count_d;
		vb = count_d;
		if (state_a_d == tltc_pkg::LIGHT_GREEN) begin
			va = green_left;
		end else if (state_b_d == tltc_pkg::LIGHT_GREEN) begin
			vb = green_left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tltc_pkg::PHASE_RESET;
			yellow_q  <= tltc_pkg::YELLOW_RESET;
			count_q   <= tltc_pkg::PHASE_RESET;
			state_a_q <= tltc_pkg::LIGHT_GREEN;
			state_b_q <= tltc_pkg::LIGHT_RED;
			enabled_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == tltc_pkg::CFG_PHASE_LENGTH) begin
					phase_q <= cfg_data;
				end else begin
					yellow_q <= cfg_data;
				end
			end
			if (adv_s2) begin
				count_q   <= count_d;
				state_a_q <= state_a_d;
				state_b_q <= state_b_d;
				enabled_q <= enabled_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s2) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			light_a_q  <= state_a_d;
			light_b_q  <= state_b_d;
			a_digits_q <= tltc_pkg::to_digits(va);
			b_digits_q <= tltc_pkg::to_digits(vb);
			changed_q  <= changed_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.light_a = light_a_q;
	assign rsp.light_b = light_b_q;
	assign rsp.a_tens  = a_digits_q[2*tltc_pkg::DIGIT_W-1:tltc_pkg::DIGIT_W];
	assign rsp.a_ones  = a_digits_q[tltc_pkg::DIGIT_W-1:0];
	assign rsp.b_tens  = b_digits_q[2*tltc_pkg::DIGIT_W-1:tltc_pkg::DIGIT_W];
	assign rsp.b_ones  = b_digits_q[tltc_pkg::DIGIT_W-1:0];
	assign rsp.changed = changed_q;

endmodule
